>>> design/linked_list_slot_manager_macros.svh
// Assertion macros shared by the linked list slot manager RTL.
// Expects clk and rst in the scope where a macro is used.
`ifndef LINKED_LIST_SLOT_MANAGER_MACROS_SVH
`define LINKED_LIST_SLOT_MANAGER_MACROS_SVH
`ifndef SYNTHESIS
`define LLSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define LLSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LLSM_ASSERT(label, prop, msg)
`define LLSM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> design/llsm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// linked list slot manager. No dependencies.
`timescale 1ns / 1ps

package llsm_pkg;

  localparam int NODE_SLOTS = 16;
  localparam int HEAD_IDX   = NODE_SLOTS;
  localparam int LINK_W     = $clog2(NODE_SLOTS + 1);
  localparam int ADDR_W     = $clog2(NODE_SLOTS);

  // Fixed field widths of the stream words
  localparam int KIND_W     = 4;
  localparam int NODE_W     = 4;
  localparam int ANS_W      = 5;
  localparam int CNT_W      = 5;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;
  localparam int OUT_PAD_W  = OUT_W - (ANS_W + CNT_W + 2 * NODE_W + 1);

  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [KIND_W-1:0] {
    K_ADD_FIRST    = 4'd0,
    K_ADD_LAST     = 4'd1,
    K_REMOVE_FIRST = 4'd2,
    K_INSERT_AFTER = 4'd3,
    K_REMOVE       = 4'd4,
    K_REMOVE_ALL   = 4'd5,
    K_NEXT         = 4'd6,
    K_PREV         = 4'd7,
    K_SELF_LINK    = 4'd8
  } kind_t;

  // Operand sources for link addresses and data
  typedef enum logic [2:0] {
    SRC_NODE,
    SRC_NEW,
    SRC_HEAD,
    SRC_HNEXT,
    SRC_HPREV,
    SRC_CUR,
    SRC_NQ,
    SRC_PQ
  } src_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_UP,
    CNT_DOWN,
    CNT_CLEAR
  } cnt_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AF1,
    ST_AF2,
    ST_AL1,
    ST_AL2,
    ST_RF1,
    ST_RF2,
    ST_IA1,
    ST_IA2,
    ST_IA3,
    ST_RM1,
    ST_RM2,
    ST_RA_INIT,
    ST_RA_READ,
    ST_RA_LINK,
    ST_RA_FIN,
    ST_QN1,
    ST_QN2,
    ST_QP1,
    ST_QP2,
    ST_SL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    src_t    rd_addr;
    logic    wn_en;
    src_t    wn_addr;
    src_t    wn_data;
    logic    wp_en;
    src_t    wp_addr;
    src_t    wp_data;
    logic    self_en;
    src_t    self_addr;
    logic    cur_load;
    src_t    cur_data;
    logic    walk_load;
    logic    walk_dec;
    cnt_op_t cnt_op;
    logic    ans_load;
    src_t    ans_sel;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    logic  in_n_ok;
    logic  in_m_ok;
    logic  cnt_zero;
    logic  walk_zero;
    logic  nq_self;
    logic  pq_self;
    logic  out_busy;
  } status_t;

endpackage

>>> design/llsm_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module llsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/llsm_ctrl.sv
// Operation sequencer for the linked list slot manager.
// Depends on llsm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "linked_list_slot_manager_macros.svh"

module llsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  llsm_pkg::status_t status,
  output llsm_pkg::cmd_t    cmd
);

  llsm_pkg::state_t state;
  llsm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      llsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (status.in_kind)
            llsm_pkg::K_ADD_FIRST:
              state_next = status.in_n_ok ? llsm_pkg::ST_AF1 : llsm_pkg::ST_DONE;
            llsm_pkg::K_ADD_LAST:
              state_next = status.in_n_ok ? llsm_pkg::ST_AL1 : llsm_pkg::ST_DONE;
            llsm_pkg::K_REMOVE_FIRST:
              state_next = status.cnt_zero ? llsm_pkg::ST_DONE : llsm_pkg::ST_RF1;
            llsm_pkg::K_INSERT_AFTER:
              state_next = (status.in_n_ok && status.in_m_ok) ? llsm_pkg::ST_IA1
                                                               : llsm_pkg::ST_DONE;
            llsm_pkg::K_REMOVE:
              state_next = status.in_n_ok ? llsm_pkg::ST_RM1 : llsm_pkg::ST_DONE;
            llsm_pkg::K_REMOVE_ALL:
              state_next = llsm_pkg::ST_RA_INIT;
            llsm_pkg::K_NEXT:
              state_next = status.in_n_ok ? llsm_pkg::ST_QN1 : llsm_pkg::ST_DONE;
            llsm_pkg::K_PREV:
              state_next = status.in_n_ok ? llsm_pkg::ST_QP1 : llsm_pkg::ST_DONE;
            llsm_pkg::K_SELF_LINK:
              state_next = status.in_n_ok ? llsm_pkg::ST_SL : llsm_pkg::ST_DONE;
            default:
              state_next = llsm_pkg::ST_DONE;
          endcase
        end
      end
      llsm_pkg::ST_AF1: begin
        cmd.wp_en    = 1'b1;
        cmd.wp_addr  = llsm_pkg::SRC_NODE;
        cmd.wp_data  = llsm_pkg::SRC_HEAD;
        cmd.wn_en    = 1'b1;
        cmd.wn_addr  = llsm_pkg::SRC_NODE;
        cmd.wn_data  = llsm_pkg::SRC_HNEXT;
        cmd.cur_load = 1'b1;
        cmd.cur_data = llsm_pkg::SRC_HNEXT;
        state_next   = llsm_pkg::ST_AF2;
      end
      llsm_pkg::ST_AF2: begin
        cmd.wp_en   = 1'b1;
        cmd.wp_addr = llsm_pkg::SRC_CUR;
        cmd.wp_data = llsm_pkg::SRC_NODE;
        cmd.wn_en   = 1'b1;
        cmd.wn_addr = llsm_pkg::SRC_HEAD;
        cmd.wn_data = llsm_pkg::SRC_NODE;
        cmd.cnt_op  = llsm_pkg::CNT_UP;
        state_next  = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_AL1: begin
        cmd.wn_en    = 1'b1;
        cmd.wn_addr  = llsm_pkg::SRC_NODE;
        cmd.wn_data  = llsm_pkg::SRC_HEAD;
        cmd.wp_en    = 1'b1;
        cmd.wp_addr  = llsm_pkg::SRC_NODE;
        cmd.wp_data  = llsm_pkg::SRC_HPREV;
        cmd.cur_load = 1'b1;
        cmd.cur_data = llsm_pkg::SRC_HPREV;
        state_next   = llsm_pkg::ST_AL2;
      end
      llsm_pkg::ST_AL2: begin
        cmd.wn_en   = 1'b1;
        cmd.wn_addr = llsm_pkg::SRC_CUR;
        cmd.wn_data = llsm_pkg::SRC_NODE;
        cmd.wp_en   = 1'b1;
        cmd.wp_addr = llsm_pkg::SRC_HEAD;
        cmd.wp_data = llsm_pkg::SRC_NODE;
        cmd.cnt_op  = llsm_pkg::CNT_UP;
        state_next  = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_RF1: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_addr  = llsm_pkg::SRC_HNEXT;
        cmd.cur_load = 1'b1;
        cmd.cur_data = llsm_pkg::SRC_HNEXT;
        state_next   = llsm_pkg::ST_RF2;
      end
      llsm_pkg::ST_RF2: begin
        // unlink the first node; its own links stay as they are
        cmd.wp_en    = 1'b1;
        cmd.wp_addr  = llsm_pkg::SRC_NQ;
        cmd.wp_data  = llsm_pkg::SRC_HEAD;
        cmd.wn_en    = 1'b1;
        cmd.wn_addr  = llsm_pkg::SRC_HEAD;
        cmd.wn_data  = llsm_pkg::SRC_NQ;
        cmd.cnt_op   = llsm_pkg::CNT_DOWN;
        cmd.ans_load = 1'b1;
        cmd.ans_sel  = llsm_pkg::SRC_CUR;
        state_next   = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_IA1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = llsm_pkg::SRC_NODE;
        cmd.wp_en   = 1'b1;
        cmd.wp_addr = llsm_pkg::SRC_NEW;
        cmd.wp_data = llsm_pkg::SRC_NODE;
        state_next  = llsm_pkg::ST_IA2;
      end
      llsm_pkg::ST_IA2: begin
        cmd.wn_en   = 1'b1;
        cmd.wn_addr = llsm_pkg::SRC_NEW;
        cmd.wn_data = llsm_pkg::SRC_NQ;
        cmd.wp_en   = 1'b1;
        cmd.wp_addr = llsm_pkg::SRC_NQ;
        cmd.wp_data = llsm_pkg::SRC_NEW;
        state_next  = llsm_pkg::ST_IA3;
      end
      llsm_pkg::ST_IA3: begin
        cmd.wn_en   = 1'b1;
        cmd.wn_addr = llsm_pkg::SRC_NODE;
        cmd.wn_data = llsm_pkg::SRC_NEW;
        cmd.cnt_op  = llsm_pkg::CNT_UP;
        state_next  = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_RM1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = llsm_pkg::SRC_NODE;
        state_next  = llsm_pkg::ST_RM2;
      end
      llsm_pkg::ST_RM2: begin
        cmd.wn_en   = 1'b1;
        cmd.wn_addr = llsm_pkg::SRC_PQ;
        cmd.wn_data = llsm_pkg::SRC_NQ;
        cmd.wp_en   = 1'b1;
        cmd.wp_addr = llsm_pkg::SRC_NQ;
        cmd.wp_data = llsm_pkg::SRC_PQ;
        cmd.cnt_op  = llsm_pkg::CNT_DOWN;
        state_next  = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_RA_INIT: begin
        cmd.cur_load  = 1'b1;
        cmd.cur_data  = llsm_pkg::SRC_HNEXT;
        cmd.walk_load = 1'b1;
        state_next    = llsm_pkg::ST_RA_READ;
      end
      llsm_pkg::ST_RA_READ: begin
        if (status.walk_zero) begin
          state_next = llsm_pkg::ST_RA_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = llsm_pkg::SRC_CUR;
          state_next  = llsm_pkg::ST_RA_LINK;
        end
      end
      llsm_pkg::ST_RA_LINK: begin
        // self-link the visited node, advance to its successor
        cmd.self_en   = 1'b1;
        cmd.self_addr = llsm_pkg::SRC_CUR;
        cmd.cur_load  = 1'b1;
        cmd.cur_data  = llsm_pkg::SRC_NQ;
        cmd.walk_dec  = 1'b1;
        state_next    = llsm_pkg::ST_RA_READ;
      end
      llsm_pkg::ST_RA_FIN: begin
        cmd.self_en   = 1'b1;
        cmd.self_addr = llsm_pkg::SRC_HEAD;
        cmd.cnt_op    = llsm_pkg::CNT_CLEAR;
        state_next    = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_QN1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = llsm_pkg::SRC_NODE;
        state_next  = llsm_pkg::ST_QN2;
      end
      llsm_pkg::ST_QN2: begin
        cmd.ans_load = !status.nq_self;
        cmd.ans_sel  = llsm_pkg::SRC_NQ;
        state_next   = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_QP1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = llsm_pkg::SRC_NODE;
        state_next  = llsm_pkg::ST_QP2;
      end
      llsm_pkg::ST_QP2: begin
        cmd.ans_load = !status.pq_self;
        cmd.ans_sel  = llsm_pkg::SRC_PQ;
        state_next   = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_SL: begin
        cmd.self_en   = 1'b1;
        cmd.self_addr = llsm_pkg::SRC_NODE;
        state_next    = llsm_pkg::ST_DONE;
      end
      llsm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = llsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = llsm_pkg::ST_IDLE;
      end
    endcase
  end

  `LLSM_ASSERT(a_out_load_free, cmd.out_load |-> !status.out_busy, "result loaded over a pending word")
  `LLSM_ASSERT(a_walk_nonzero, (state == llsm_pkg::ST_RA_LINK) |-> !status.walk_zero, "walk step with no members left")

endmodule

>>> design/llsm_dp.sv
// Datapath of the linked list slot manager: link RAMs with valid bits, head
// links, count, walk cursor and output word register. Uses llsm_pkg, llsm_ram.
`timescale 1ns / 1ps
`include "linked_list_slot_manager_macros.svh"

module llsm_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [llsm_pkg::IN_W-1:0]  in_data,
  input  llsm_pkg::cmd_t             cmd,
  output llsm_pkg::status_t          status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [llsm_pkg::OUT_W-1:0] out_data,
  output logic                       out_user
);

  localparam llsm_pkg::link_t HEAD  = llsm_pkg::LINK_W'(llsm_pkg::HEAD_IDX);
  localparam llsm_pkg::link_t SLOTS = llsm_pkg::LINK_W'(llsm_pkg::NODE_SLOTS);

  logic [llsm_pkg::NODE_W-1:0] node_q;
  logic [llsm_pkg::NODE_W-1:0] new_q;
  llsm_pkg::link_t             head_next;
  llsm_pkg::link_t             head_prev;
  llsm_pkg::link_t             cur;
  llsm_pkg::link_t             walk;
  llsm_pkg::link_t             count;
  llsm_pkg::link_t             ans;
  logic                        ans_null;
  logic [llsm_pkg::NODE_SLOTS-1:0] next_valid;
  logic [llsm_pkg::NODE_SLOTS-1:0] prev_valid;

  // read snapshot taken when a read is issued
  llsm_pkg::link_t rd_link;
  logic            rd_head;
  llsm_pkg::link_t hn_snap;
  llsm_pkg::link_t hp_snap;
  logic            nv_snap;
  logic            pv_snap;
  llsm_pkg::link_t n_ram_q;
  llsm_pkg::link_t p_ram_q;
  llsm_pkg::link_t nq;
  llsm_pkg::link_t pq;

  llsm_pkg::link_t rd_addr_v;
  llsm_pkg::link_t wn_addr_v;
  llsm_pkg::link_t wn_data_v;
  llsm_pkg::link_t wp_addr_v;
  llsm_pkg::link_t wp_data_v;
  llsm_pkg::link_t self_addr_v;
  llsm_pkg::link_t cur_data_v;
  llsm_pkg::link_t ans_v;
  logic            wn_head;
  logic            wp_head;
  logic            self_head;

  logic [llsm_pkg::ADDR_W-1:0] rd_idx;
  logic [llsm_pkg::ADDR_W-1:0] wn_idx;
  logic [llsm_pkg::ADDR_W-1:0] wp_idx;
  logic [llsm_pkg::ADDR_W-1:0] self_idx;

  function automatic llsm_pkg::link_t src_val(input llsm_pkg::src_t s);
    llsm_pkg::link_t v;
    unique case (s)
      llsm_pkg::SRC_NODE:  v = llsm_pkg::LINK_W'(node_q);
      llsm_pkg::SRC_NEW:   v = llsm_pkg::LINK_W'(new_q);
      llsm_pkg::SRC_HEAD:  v = HEAD;
      llsm_pkg::SRC_HNEXT: v = head_next;
      llsm_pkg::SRC_HPREV: v = head_prev;
      llsm_pkg::SRC_CUR:   v = cur;
      llsm_pkg::SRC_NQ:    v = nq;
      llsm_pkg::SRC_PQ:    v = pq;
      default:             v = HEAD;
    endcase
    return v;
  endfunction

  // an entry never written since its last self-link reads as its own index
  assign nq = rd_head ? hn_snap : (nv_snap ? n_ram_q : rd_link);
  assign pq = rd_head ? hp_snap : (pv_snap ? p_ram_q : rd_link);

  always_comb begin
    rd_addr_v   = src_val(cmd.rd_addr);
    wn_addr_v   = src_val(cmd.wn_addr);
    wn_data_v   = src_val(cmd.wn_data);
    wp_addr_v   = src_val(cmd.wp_addr);
    wp_data_v   = src_val(cmd.wp_data);
    self_addr_v = src_val(cmd.self_addr);
    cur_data_v  = src_val(cmd.cur_data);
    ans_v       = src_val(cmd.ans_sel);
    wn_head     = (wn_addr_v == HEAD);
    wp_head     = (wp_addr_v == HEAD);
    self_head   = (self_addr_v == HEAD);
    rd_idx      = rd_addr_v[llsm_pkg::ADDR_W-1:0];
    wn_idx      = wn_addr_v[llsm_pkg::ADDR_W-1:0];
    wp_idx      = wp_addr_v[llsm_pkg::ADDR_W-1:0];
    self_idx    = self_addr_v[llsm_pkg::ADDR_W-1:0];
  end

  llsm_ram #(
    .WIDTH (llsm_pkg::LINK_W),
    .DEPTH (llsm_pkg::NODE_SLOTS)
  ) u_next_ram (
    .clk   (clk),
    .we    (cmd.wn_en && !wn_head),
    .waddr (wn_idx),
    .wdata (wn_data_v),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (n_ram_q)
  );

  llsm_ram #(
    .WIDTH (llsm_pkg::LINK_W),
    .DEPTH (llsm_pkg::NODE_SLOTS)
  ) u_prev_ram (
    .clk   (clk),
    .we    (cmd.wp_en && !wp_head),
    .waddr (wp_idx),
    .wdata (wp_data_v),
    .re    (cmd.rd_en),
    .raddr (rd_idx),
    .rdata (p_ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head_next  <= HEAD;
      head_prev  <= HEAD;
      next_valid <= '0;
      prev_valid <= '0;
      count      <= '0;
      walk       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.wn_en) begin
        if (wn_head) begin
          head_next <= wn_data_v;
        end else begin
          next_valid[wn_idx] <= 1'b1;
        end
      end
      if (cmd.wp_en) begin
        if (wp_head) begin
          head_prev <= wp_data_v;
        end else begin
          prev_valid[wp_idx] <= 1'b1;
        end
      end
      if (cmd.self_en) begin
        if (self_head) begin
          head_next <= HEAD;
          head_prev <= HEAD;
        end else begin
          next_valid[self_idx] <= 1'b0;
          prev_valid[self_idx] <= 1'b0;
        end
      end
      unique case (cmd.cnt_op)
        llsm_pkg::CNT_HOLD:  count <= count;
        llsm_pkg::CNT_UP:    count <= (count == SLOTS) ? count : count + 1'b1;
        llsm_pkg::CNT_DOWN:  count <= (count == '0) ? count : count - 1'b1;
        llsm_pkg::CNT_CLEAR: count <= '0;
      endcase
      if (cmd.walk_load) begin
        walk <= count;
      end else if (cmd.walk_dec) begin
        walk <= walk - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      node_q   <= in_data[7:4];
      new_q    <= in_data[11:8];
      ans      <= '0;
      ans_null <= 1'b1;
    end else if (cmd.ans_load) begin
      ans      <= ans_v;
      ans_null <= 1'b0;
    end
    if (cmd.rd_en) begin
      rd_link <= rd_addr_v;
      rd_head <= (rd_addr_v == HEAD);
      hn_snap <= head_next;
      hp_snap <= head_prev;
      nv_snap <= next_valid[rd_idx];
      pv_snap <= prev_valid[rd_idx];
    end
    if (cmd.cur_load) begin
      cur <= cur_data_v;
    end
    if (cmd.out_load) begin
      out_data <= {
        llsm_pkg::OUT_PAD_W'(0),
        (count == '0),
        (count == '0) ? '0 : head_prev[llsm_pkg::NODE_W-1:0],
        (count == '0) ? '0 : head_next[llsm_pkg::NODE_W-1:0],
        llsm_pkg::CNT_W'(count),
        llsm_pkg::ANS_W'(ans)
      };
      out_user <= ans_null;
    end
  end

  always_comb begin
    status.in_kind   = llsm_pkg::kind_t'(in_data[3:0]);
    status.in_n_ok   = llsm_pkg::LINK_W'(in_data[7:4]) < SLOTS;
    status.in_m_ok   = llsm_pkg::LINK_W'(in_data[11:8]) < SLOTS;
    status.cnt_zero  = (count == '0);
    status.walk_zero = (walk == '0);
    status.nq_self   = (nq == llsm_pkg::LINK_W'(node_q));
    status.pq_self   = (pq == llsm_pkg::LINK_W'(node_q));
    status.out_busy  = out_valid && !out_ready;
  end

  `LLSM_ASSERT(a_count_range, count <= SLOTS, "member count above slot total")
  `LLSM_ASSERT(a_head_range, (head_next <= HEAD) && (head_prev <= HEAD), "head link out of range")
  `LLSM_ASSERT(a_self_alone, cmd.self_en |-> !(cmd.wn_en || cmd.wp_en), "self-link overlaps a link write")
  `LLSM_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && (count == '0)), "reset left state behind")

endmodule

>>> design/linked_list_slot_manager.sv
// Top level of the linked list slot manager: sequencer plus datapath.
// Uses llsm_pkg, llsm_ctrl, llsm_dp (which holds the llsm_ram link tables).
//
// One circular doubly linked list over 16 node slots with a sentinel head
// (index 16). Each input word carries one operation; each yields exactly one
// result word with the answer node, the count, the first and last nodes and
// an empty flag, answer_null on tuser. Items are handled one at a time: the
// next word is taken once the current result sits in the output register,
// even if that word is still waiting downstream. The next and prev tables
// live in two RAMs with one write and one registered read port each. Remove
// all walks the members one at a time, self-linking each, then resets the
// head links and clears the count. A stall of the previous result delays
// the next accept. Reset is synchronous; per-entry valid bits stand in for
// the self-linked reset contents, so no clearing pass is needed.
`timescale 1ns / 1ps

module linked_list_slot_manager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] kind, [7:4] node, [11:8] new_node, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] answer_node, [9:5] node_count, [13:10] first_node,
  // [17:14] last_node, [18] list_empty, [23:19] zero
  output logic [23:0] m_axis_tdata,
  // [0] answer_null
  output logic        m_axis_tuser
);

  llsm_pkg::cmd_t    cmd;
  llsm_pkg::status_t status;

  llsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  llsm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule
